[src/acf_pkg.sv]
`default_nettype none

package acf_pkg;

   localparam int CHAR_W  = 8;
   localparam int LEN_W   = 9;
   localparam int LIMIT_W = 13;
   localparam int COUNT_W = 12;
   localparam int ENTRY_W = 3 * CHAR_W;

   localparam logic [CHAR_W-1:0]  CONFIRM_MARK = 8'h5E;
   localparam logic [CHAR_W-1:0]  NULL_CHAR    = 8'h00;
   localparam logic [LIMIT_W-1:0] LIMIT_CAP    = 13'd4096;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 13'd256;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SYMBOL = 1'b1
   } op_type;

   typedef enum logic {
      REG_ALPHABET_LEN = 1'b0,
      REG_OUTPUT_LIMIT = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic write_entry;
      logic start;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_symbol;
      logic skip;
      logic scan_done;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

[src/acf_ram.sv]
`default_nettype none

module acf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/acf_ctrl.sv]
`default_nettype none

module acf_ctrl
   import acf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.is_symbol) begin
               state_in = status.skip ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      cmd.write_entry = 1'b0;
      cmd.start       = 1'b0;
      cmd.scan        = 1'b0;
      cmd.finish      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready      = 1'b1;
            cmd.write_entry = req_tvalid && !status.is_symbol;
            cmd.start       = req_tvalid && status.is_symbol;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_DONE: begin
            cmd.finish = status.rsp_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[src/acf_datapath.sv]
`default_nettype none

module acf_datapath
   import acf_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output      status_type         status,
   input  wire logic [39:0]        req_tdata,
   input  wire logic               req_tuser,
   input  wire logic               req_tlast,
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   output      logic [7:0]         rsp_tdata,
   output      logic               rsp_tuser,
   output      logic               rsp_tlast,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CW     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [CHAR_W-1:0] in_index;
   logic [CHAR_W-1:0] in_base;
   logic [CHAR_W-1:0] in_variant;
   logic [CHAR_W-1:0] in_confirm;
   logic [CHAR_W-1:0] in_symbol;

   assign in_index   = req_tdata[7:0];
   assign in_base    = req_tdata[15:8];
   assign in_variant = req_tdata[23:16];
   assign in_confirm = req_tdata[31:24];
   assign in_symbol  = req_tdata[39:32];

   logic [LEN_W-1:0]   len_ff;
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_ALPHABET_LEN: len_ff   <= csr_wdata[LEN_W-1:0];
            REG_OUTPUT_LIMIT: limit_ff <= csr_wdata;
         endcase
      end
   end

   logic [CW-1:0] len_ext;
   logic [CW-1:0] search_len;
   logic [CW-1:0] idx_ext;
   logic          load_ok;

   assign len_ext    = CW'(len_ff);
   assign search_len = (len_ext > DEPTH_C) ? DEPTH_C : len_ext;
   assign idx_ext    = CW'(in_index);
   assign load_ok    = idx_ext < DEPTH_C;

   logic [CW-1:0]      cnt_ff,   cnt_in;
   logic               pend_ff,  pend_in;
   logic               plast_ff, plast_in;
   logic [CHAR_W-1:0]  sym_ff;
   logic               last_ff;
   logic               found_ff, found_in;
   logic               vhit_ff,  vhit_in;
   logic [CHAR_W-1:0]  mapped_ff, mapped_in;
   logic [ENTRY_W-1:0] rd_data;
   logic               issue;
   logic               eval;
   logic               base_hit;
   logic               var_hit;

   acf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_entry && load_ok),
      .wr_addr (idx_ext[ADDR_W-1:0]),
      .wr_data ({in_confirm, in_variant, in_base}),
      .rd_en   (issue),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign eval     = cmd.scan && pend_ff;
   assign base_hit = rd_data[7:0] == sym_ff;
   assign var_hit  = rd_data[15:8] == sym_ff;

   assign status.scan_done = eval && (base_hit || plast_ff);
   assign issue            = cmd.scan && (cnt_ff < search_len) && !status.scan_done;

   always_comb begin
      cnt_in    = cnt_ff;
      pend_in   = issue;
      plast_in  = cnt_ff == (search_len - CW'(1));
      found_in  = found_ff;
      vhit_in   = vhit_ff;
      mapped_in = mapped_ff;
      if (cmd.start) begin
         cnt_in   = '0;
         pend_in  = 1'b0;
         found_in = 1'b0;
         vhit_in  = 1'b0;
      end else begin
         if (issue) begin
            cnt_in = cnt_ff + CW'(1);
         end
         if (eval) begin
            priority if (base_hit) begin
               found_in = 1'b1;
            end else if (var_hit && !vhit_ff) begin
               vhit_in   = 1'b1;
               mapped_in = (rd_data[23:16] == CONFIRM_MARK) ? rd_data[7:0] : NULL_CHAR;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
         vhit_ff  <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         found_ff <= found_in;
         vhit_ff  <= vhit_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      plast_ff  <= plast_in;
      mapped_ff <= mapped_in;
      if (cmd.start) begin
         sym_ff  <= in_symbol;
         last_ff <= req_tlast;
      end
   end

   assign status.is_symbol = op_type'(req_tuser) == OP_SYMBOL;
   assign status.skip      = (in_symbol == NULL_CHAR) || (search_len == '0);

   logic [LIMIT_W-1:0] limit_capped;
   logic [COUNT_W-1:0] cap;
   logic [CHAR_W-1:0]  result_char;
   logic               emit;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign limit_capped = (limit_ff > LIMIT_CAP) ? LIMIT_CAP : limit_ff;
   assign cap          = (limit_capped == '0) ? '0 : COUNT_W'(limit_capped - LIMIT_W'(1));
   assign result_char  = found_ff ? sym_ff : (vhit_ff ? mapped_ff : NULL_CHAR);
   assign emit         = (result_char != NULL_CHAR) && (count_ff < cap);

   always_comb begin
      count_in = count_ff;
      if (cmd.finish) begin
         if (emit) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if (last_ff) begin
            count_in = '0;
         end
      end
   end

   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_flag_ff;
   logic              rsp_last_ff;

   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_char_ff <= emit ? result_char : NULL_CHAR;
         rsp_flag_ff <= emit;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_flag_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_flag_ff == (rsp_char_ff != NULL_CHAR)))
      else $error("Result flag disagrees with result character.");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("Result register overwritten while full.");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd.scan))
      else $error("Table read pending outside a scan.");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      issue |-> (cnt_ff < search_len))
      else $error("Table read past the searched entries.");
`endif

endmodule

`default_nettype wire

[src/alphabet_char_filter_unit.sv]
`default_nettype none

// Alphabet character filter. A req beat with tuser 0 loads one table entry (base,
// variant and confirm characters). A req beat with tuser 1 filters one symbol and
// yields one rsp beat: the kept or mapped character with tuser set, or a zero
// character with tuser clear when it is dropped; rsp tlast echoes req tlast, which
// closes the line and clears the per-line character count. The search reads the
// searched table entries from one RAM, one entry per cycle; a base match ends
// the search early, and a null symbol or an empty table skips the search. The
// finished beat waits in an output register, so the next item can start meanwhile.
module alphabet_char_filter_unit
   import acf_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   // entry_index, base_char, variant_char, confirm_char, symbol
   input  wire logic [39:0]        req_tdata,
   // op
   input  wire logic               req_tuser,
   input  wire logic               req_tlast,
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   // out_char
   output      logic [7:0]         rsp_tdata,
   // char_valid
   output      logic               rsp_tuser,
   output      logic               rsp_tlast,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   acf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   acf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire
